@@ hdl/fca_pkg.sv @@
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types, codes and constants of the chain allocator.
// ----------------------------------------------------------------------------
package fca_pkg;

   localparam int MAX_BLOCKS_DEFAULT = 4096;
   localparam int CFG_W              = 13;
   localparam int BLK_W              = 12;
   localparam int CNT_W              = 13;

   // Table entry codes; any value at or above FIRST_ALLOC is a pointer.
   localparam logic [BLK_W-1:0] ENTRY_FREE  = 12'd0;
   localparam logic [BLK_W-1:0] ENTRY_EOC   = 12'd1;
   localparam logic [BLK_W-1:0] ENTRY_BUSY  = 12'd2;
   localparam logic [BLK_W-1:0] FIRST_ALLOC = 12'd3;

   localparam logic [2:0] OP_FORMAT  = 3'd0;
   localparam logic [2:0] OP_ALLOC   = 3'd1;
   localparam logic [2:0] OP_ADVANCE = 3'd2;
   localparam logic [2:0] OP_FOLLOW  = 3'd3;
   localparam logic [2:0] OP_FREE    = 3'd4;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOFREE = 2'd1;
   localparam logic [1:0] ST_BADBLK = 2'd2;
   localparam logic [1:0] ST_BROKEN = 2'd3;

   localparam logic CSR_BLOCKS_IDX   = 1'b0;
   localparam logic CSR_RESERVED_IDX = 1'b1;

   localparam logic [CFG_W-1:0] BLOCKS_RESET   = 13'd4096;
   localparam logic [CFG_W-1:0] RESERVED_RESET = 13'd3;

   typedef struct packed {
      logic [2:0]       operation;
      logic [BLK_W-1:0] block;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [BLK_W-1:0] block_out;
      logic             end_of_chain;
      logic [CNT_W-1:0] freed_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_FMT,
      S_SCAN,
      S_EVAL,
      S_LINK,
      S_MARK,
      S_WALK,
      S_FINISH
   } fca_state_type;

   typedef enum logic [1:0] {
      BOUT_ZERO,
      BOUT_FOUND,
      BOUT_NEXT
   } bout_sel_type;

   typedef struct packed {
      logic         load_req;
      logic         fmt_start;
      logic         fmt_write;
      logic         scan_start;
      logic         scan_step;
      logic         rd_blk;
      logic         rd_next;
      logic         wr_link;
      logic         wr_mark;
      logic         free_cur;
      logic         set_res;
      logic [1:0]   res_status;
      bout_sel_type res_bout;
      logic         res_eoc;
      logic         push;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       blk_bad;
      logic       e_free;
      logic       e_eoc;
      logic       e_busy;
      logic       e_ge_lim;
      logic       e_self;
      logic       scan_hit;
      logic       scan_miss;
      logic       fmt_last;
      logic       rsp_free;
   } stat_type;

endpackage

@@ hdl/fca_datapath.sv @@
// ----------------------------------------------------------------------------
// fca_datapath
// Table memory, scan and walk pointers, configuration and result registers.
// ----------------------------------------------------------------------------
module fca_datapath
   import fca_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  req_type             req_data,
   output rsp_type             rsp_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [CFG_W-1:0]    csr_wdata,
   input  cmd_type             cmd,
   output stat_type            stat
);

   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int W  = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

   logic [BLK_W-1:0] mem [MAX_BLOCKS];

   logic [CFG_W-1:0] cfg_blocks_ff, cfg_blocks_in;
   logic [CFG_W-1:0] cfg_res_ff, cfg_res_in;
   logic [2:0]       op_ff;
   logic [BLK_W-1:0] blk_ff;
   logic [W-1:0]     cur_ff, cur_in;
   logic             scan_vld_ff, scan_vld_in;
   logic [AW-1:0]    rd_addr_ff;
   logic [BLK_W-1:0] rd_data_ff;
   logic [CNT_W-1:0] freed_ff, freed_in;
   logic [1:0]       res_status_ff;
   logic [BLK_W-1:0] res_bout_ff, res_bout_in;
   logic             res_eoc_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;

   logic [W-1:0]     lim;
   logic [W-1:0]     res_lim;
   logic             scan_go;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [BLK_W-1:0] wr_data;

   assign lim = (W'(cfg_blocks_ff) > W'(MAX_BLOCKS)) ? W'(MAX_BLOCKS) : W'(cfg_blocks_ff);
   // At least the three low blocks are always marked busy.
   assign res_lim = (cfg_res_ff < CFG_W'(FIRST_ALLOC)) ? W'(FIRST_ALLOC) : W'(cfg_res_ff);
   assign scan_go = cmd.scan_step && (cur_ff < lim);

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = rd_addr_ff;
      if (scan_go) begin
         rd_en   = 1'b1;
         rd_addr = cur_ff[AW-1:0];
      end else if (cmd.rd_blk) begin
         rd_en   = 1'b1;
         rd_addr = AW'(blk_ff);
      end else if (cmd.rd_next) begin
         rd_en   = 1'b1;
         rd_addr = AW'(rd_data_ff);
      end
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = rd_addr_ff;
      wr_data = ENTRY_FREE;
      if (cmd.fmt_write) begin
         wr_addr = cur_ff[AW-1:0];
         wr_data = (cur_ff < res_lim) ? ENTRY_BUSY : ENTRY_FREE;
      end else if (cmd.wr_link) begin
         wr_addr = AW'(blk_ff);
         wr_data = BLK_W'(rd_addr_ff);
      end else if (cmd.wr_mark) begin
         wr_data = ENTRY_EOC;
      end else if (!cmd.free_cur) begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_comb begin
      cfg_blocks_in = cfg_blocks_ff;
      cfg_res_in    = cfg_res_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BLOCKS_IDX:   cfg_blocks_in = csr_wdata;
            CSR_RESERVED_IDX: cfg_res_in    = csr_wdata;
            default: begin
               cfg_blocks_in = cfg_blocks_ff;
            end
         endcase
      end
   end

   always_comb begin
      cur_in      = cur_ff;
      scan_vld_in = scan_vld_ff;
      if (cmd.fmt_start) begin
         cur_in = '0;
      end else if (cmd.fmt_write) begin
         cur_in = cur_ff + W'(1);
      end else if (cmd.scan_start) begin
         cur_in      = W'(FIRST_ALLOC);
         scan_vld_in = 1'b0;
      end else if (cmd.scan_step) begin
         scan_vld_in = scan_go;
         if (scan_go) begin
            cur_in = cur_ff + W'(1);
         end
      end
   end

   always_comb begin
      freed_in = freed_ff;
      if (cmd.load_req) begin
         freed_in = '0;
      end else if (cmd.free_cur) begin
         freed_in = freed_ff + CNT_W'(1);
      end
   end

   always_comb begin
      case (cmd.res_bout)
         BOUT_FOUND: res_bout_in = BLK_W'(rd_addr_ff);
         BOUT_NEXT:  res_bout_in = rd_data_ff;
         default:    res_bout_in = '0;
      endcase
   end

   assign rsp_valid_in = cmd.push ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_blocks_ff <= BLOCKS_RESET;
         cfg_res_ff    <= RESERVED_RESET;
         scan_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_blocks_ff <= cfg_blocks_in;
         cfg_res_ff    <= cfg_res_in;
         scan_vld_ff   <= scan_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      freed_ff <= freed_in;
      if (cmd.load_req) begin
         op_ff  <= req_data.operation;
         blk_ff <= req_data.block;
      end
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_status;
         res_bout_ff   <= res_bout_in;
         res_eoc_ff    <= cmd.res_eoc;
      end
      if (cmd.push) begin
         rsp_data_ff.status       <= res_status_ff;
         rsp_data_ff.block_out    <= res_bout_ff;
         rsp_data_ff.end_of_chain <= res_eoc_ff;
         rsp_data_ff.freed_count  <= freed_ff;
      end
   end

   always_comb begin
      stat.op        = op_ff;
      stat.blk_bad   = W'(blk_ff) >= lim;
      stat.e_free    = rd_data_ff == ENTRY_FREE;
      stat.e_eoc     = rd_data_ff == ENTRY_EOC;
      stat.e_busy    = rd_data_ff == ENTRY_BUSY;
      stat.e_ge_lim  = W'(rd_data_ff) >= lim;
      // A pointer back to its own block would be read while it is being freed.
      stat.e_self    = W'(rd_data_ff) == W'(rd_addr_ff);
      stat.scan_hit  = scan_vld_ff && (rd_data_ff == ENTRY_FREE);
      stat.scan_miss = !scan_vld_ff && (cur_ff >= lim);
      stat.fmt_last  = cur_ff == W'(MAX_BLOCKS - 1);
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("table read and write hit the same entry in one cycle");

   a_push_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before it was taken");

   a_bout_is_pointer: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.block_out != '0)) |->
      ((rsp_data_ff.block_out >= FIRST_ALLOC) && (rsp_data_ff.status == ST_OK)))
      else $error("returned block is not an allocatable block");

   a_fmt_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.fmt_write |-> (cur_ff < W'(MAX_BLOCKS)))
      else $error("format sweep ran past the table");
`endif

endmodule

@@ hdl/fca_controller.sv @@
// ----------------------------------------------------------------------------
// fca_controller
// Sequencer for format, free-block scan, chain follow and chain release.
// ----------------------------------------------------------------------------
module fca_controller
   import fca_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   fca_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (stat.op)
               OP_FORMAT: state_in = S_FMT;
               OP_ALLOC:  state_in = S_SCAN;
               OP_ADVANCE, OP_FOLLOW: state_in = stat.blk_bad ? S_FINISH : S_EVAL;
               OP_FREE:   state_in = stat.blk_bad ? S_FINISH : S_WALK;
               default:   state_in = S_FINISH;
            endcase
         end
         S_FMT: begin
            if (stat.fmt_last) state_in = S_FINISH;
         end
         S_SCAN: begin
            if (stat.scan_hit) begin
               state_in = (stat.op == OP_ADVANCE) ? S_LINK : S_MARK;
            end else if (stat.scan_miss) begin
               state_in = S_FINISH;
            end
         end
         S_EVAL: begin
            if (stat.e_eoc && stat.op == OP_ADVANCE) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_LINK: state_in = S_MARK;
         S_MARK: state_in = S_FINISH;
         S_WALK: begin
            if (stat.e_free || stat.e_busy || stat.e_eoc || stat.e_ge_lim || stat.e_self) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.res_bout = BOUT_ZERO;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         S_DECODE: begin
            case (stat.op)
               OP_FORMAT: cmd.fmt_start  = 1'b1;
               OP_ALLOC:  cmd.scan_start = 1'b1;
               OP_ADVANCE, OP_FOLLOW, OP_FREE: begin
                  if (stat.blk_bad) begin
                     cmd.set_res    = 1'b1;
                     cmd.res_status = ST_BADBLK;
                  end else begin
                     cmd.rd_blk = 1'b1;
                  end
               end
               default: begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = ST_OK;
               end
            endcase
         end
         S_FMT: begin
            cmd.fmt_write = 1'b1;
            if (stat.fmt_last) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ST_OK;
            end
         end
         S_SCAN: begin
            if (!stat.scan_hit) begin
               if (stat.scan_miss) begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = ST_NOFREE;
                  cmd.res_eoc    = stat.op == OP_ADVANCE;
               end else begin
                  cmd.scan_step = 1'b1;
               end
            end
         end
         S_EVAL: begin
            if (stat.e_free || stat.e_busy) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ST_BROKEN;
            end else if (stat.e_eoc) begin
               if (stat.op == OP_ADVANCE) begin
                  cmd.scan_start = 1'b1;
               end else begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = ST_OK;
                  cmd.res_eoc    = 1'b1;
               end
            end else if (stat.e_ge_lim) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ST_BROKEN;
            end else begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ST_OK;
               cmd.res_bout   = BOUT_NEXT;
            end
         end
         S_LINK: cmd.wr_link = 1'b1;
         S_MARK: begin
            cmd.wr_mark    = 1'b1;
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_bout   = BOUT_FOUND;
            cmd.res_eoc    = stat.op == OP_ADVANCE;
         end
         S_WALK: begin
            if (stat.e_free || stat.e_busy) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ST_BROKEN;
            end else begin
               cmd.free_cur = 1'b1;
               if (stat.e_eoc) begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = ST_OK;
               end else if (stat.e_ge_lim || stat.e_self) begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = ST_BROKEN;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         S_FINISH: cmd.push = stat.rsp_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.fmt_write, cmd.wr_link, cmd.wr_mark, cmd.free_cur}) <= 1)
      else $error("more than one table write issued in a cycle");

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted request was not decoded");

   a_link_then_mark: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_link |=> cmd.wr_mark)
      else $error("linked block was not marked end of chain");
`endif

endmodule

@@ hdl/fat_chain_allocator.sv @@
// ----------------------------------------------------------------------------
// fat_chain_allocator
// Block allocation table with chain allocate, follow, extend and release.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_ready with an operation and a block number;
// each request yields exactly one result on rsp_valid/rsp_ready. The csr_ port
// writes the disk size or the reserved block count, as csr_index selects.
// Steps after acceptance; a bad block number or unknown operation skips them:
//   format         sweeps the whole table (one table entry is written per cycle)
//   allocate       search from block 3 up, then marks the free block found
//   follow next    reads the given block's entry and returns the next block
//   advance/extend as follow; at a chain end also search, link and mark
//   free chain     walks the chain and releases each entry in turn
// The search and the chain walk each move one table entry per cycle through
// the single read port of the table memory. One request is worked on at a
// time, so the next one is taken in the idle state after the previous result
// is loaded; it is taken while that result still waits in the output register,
// and the block stalls in its final step while that register is full.
// Reset restores both configuration registers and empties the output
// register; the table holds no defined content until the first format.
// ----------------------------------------------------------------------------
module fat_chain_allocator
   import fca_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   fca_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fca_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

@@ test/tb_fat_chain_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fat_chain_allocator
// Self-checking bench for the chain allocator. Directed requests cover the
// field and register extremes, every operation and the error statuses. Random
// requests then work mostly on live chains under several idle and stall
// patterns. A predictor keeps its own copy of the allocation table and checks
// every result in order.
// ----------------------------------------------------------------------------
module tb_fat_chain_allocator;
   import fca_pkg::*;

   localparam int NBLK        = MAX_BLOCKS_DEFAULT;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SHOW_MAX    = 10;
   localparam int PHASE_ITEMS = 23;

   typedef struct packed {
      req_type rq;
      rsp_type rs;
   } awaited_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en = 1'b0;
   logic             csr_index = CSR_BLOCKS_IDX;
   logic [CFG_W-1:0] csr_wdata = '0;

   // Predicted table and geometry.
   logic [BLK_W-1:0] fat_tbl [NBLK];
   logic [CFG_W-1:0] disk_blocks   = BLOCKS_RESET;
   logic [CFG_W-1:0] disk_reserved = RESERVED_RESET;

   awaited_type awaited_q[$];
   awaited_type head;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left     = 0;
   int fail_cnt      = 0;
   int mismatch_cnt  = 0;
   int checked_cnt   = 0;
   int cycle_cnt     = 0;
   int op_cnt [8];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fat_chain_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   function automatic int cur_limit();
      return (disk_blocks > NBLK) ? NBLK : int'(disk_blocks);
   endfunction

   function automatic int first_free();
      int lim;
      int i;
      int hit;
      lim = cur_limit();
      hit = -1;
      for (i = FIRST_ALLOC; i < lim && hit < 0; i++)
         if (fat_tbl[i] == ENTRY_FREE) hit = i;
      return hit;
   endfunction

   // Applies one request to the predicted table and returns its result.
   function automatic rsp_type fat_apply(input req_type r);
      rsp_type          o;
      int               lim;
      int               res;
      int               nb;
      int               i;
      logic [BLK_W-1:0] e;
      bit               done;
      o   = '0;
      lim = cur_limit();
      case (r.operation)
         OP_FORMAT: begin
            for (i = 0; i < NBLK; i++) fat_tbl[i] = ENTRY_FREE;
            res = (disk_reserved < FIRST_ALLOC) ? int'(FIRST_ALLOC) : int'(disk_reserved);
            for (i = 0; i < res && i < NBLK; i++) fat_tbl[i] = ENTRY_BUSY;
         end
         OP_ALLOC: begin
            nb = first_free();
            if (nb >= 0) begin
               fat_tbl[nb] = ENTRY_EOC;
               o.block_out = BLK_W'(nb);
            end else begin
               o.status = ST_NOFREE;
            end
         end
         OP_ADVANCE, OP_FOLLOW: begin
            if (r.block >= lim) begin
               o.status = ST_BADBLK;
            end else begin
               e = fat_tbl[r.block];
               if (e == ENTRY_FREE || e == ENTRY_BUSY) begin
                  o.status = ST_BROKEN;
               end else if (e == ENTRY_EOC) begin
                  o.end_of_chain = 1'b1;
                  if (r.operation == OP_ADVANCE) begin
                     nb = first_free();
                     if (nb >= 0) begin
                        fat_tbl[r.block] = BLK_W'(nb);
                        fat_tbl[nb]      = ENTRY_EOC;
                        o.block_out      = BLK_W'(nb);
                     end else begin
                        o.status = ST_NOFREE;
                     end
                  end
               end else if (e >= lim) begin
                  o.status = ST_BROKEN;
               end else begin
                  o.block_out = e;
               end
            end
         end
         OP_FREE: begin
            if (r.block >= lim) begin
               o.status = ST_BADBLK;
            end else begin
               nb   = r.block;
               i    = 0;
               done = 1'b0;
               while (!done && i <= lim) begin
                  e = fat_tbl[nb];
                  if (e == ENTRY_FREE || e == ENTRY_BUSY) begin
                     o.status = ST_BROKEN;
                     done     = 1'b1;
                  end else begin
                     fat_tbl[nb]   = ENTRY_FREE;
                     o.freed_count = o.freed_count + 1'b1;
                     if (e == ENTRY_EOC) begin
                        done = 1'b1;
                     end else if (e >= lim) begin
                        o.status = ST_BROKEN;
                        done     = 1'b1;
                     end else begin
                        nb = e;
                     end
                  end
                  if (!done) i++;
               end
               if (i > lim) o.status = ST_BROKEN;
            end
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   function automatic req_type mk_req(input logic [2:0] op, input logic [BLK_W-1:0] blk);
      req_type r;
      r.operation = op;
      r.block     = blk;
      return r;
   endfunction

   function automatic logic [BLK_W-1:0] in_range_block();
      int lim;
      lim = cur_limit();
      return (lim > 0) ? BLK_W'($urandom_range(lim - 1)) : '0;
   endfunction

   // Picks a block of a chain (only a tail if asked), or any in-range block if none.
   function automatic logic [BLK_W-1:0] pick_chain_block(input bit tail_only);
      logic [BLK_W-1:0] cand[$];
      int               lim;
      int               i;
      lim = cur_limit();
      for (i = FIRST_ALLOC; i < lim; i++)
         if (fat_tbl[i] == ENTRY_EOC || (!tail_only && fat_tbl[i] >= FIRST_ALLOC))
            cand.push_back(BLK_W'(i));
      if (cand.size() == 0) return in_range_block();
      return cand[$urandom_range(cand.size() - 1)];
   endfunction

   // The caller is always at a rising edge; valid is lowered or reloaded here,
   // never both in one step.
   task automatic send_request(input req_type r);
      awaited_type a;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      a.rq = r;
      a.rs = fat_apply(r);
      awaited_q.push_back(a);
      op_cnt[r.operation]++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_q.size() != 0);
   endtask

   task automatic set_geometry(input logic [CFG_W-1:0] blocks,
                               input logic [CFG_W-1:0] reserved);
      drain_results();
      repeat (8) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_BLOCKS_IDX;
      csr_wdata <= blocks;
      @(posedge clock);
      csr_index <= CSR_RESERVED_IDX;
      csr_wdata <= reserved;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      disk_blocks   = blocks;
      disk_reserved = reserved;
   endtask

   task automatic test_basic_chain();
      set_geometry(13'd16, 13'd5);
      send_request(mk_req(OP_FORMAT, 12'd0));
      send_request(mk_req(OP_ALLOC, 12'hFFF));
      send_request(mk_req(OP_ALLOC, 12'd0));
      // The first advance extends the chain, the second only follows it.
      send_request(mk_req(OP_ADVANCE, 12'd6));
      send_request(mk_req(OP_ADVANCE, 12'd6));
      send_request(mk_req(OP_FOLLOW, 12'd7));
      send_request(mk_req(OP_FOLLOW, 12'd0));
      send_request(mk_req(OP_FOLLOW, 12'd10));
      send_request(mk_req(OP_ADVANCE, 12'd16));
      send_request(mk_req(OP_FREE, 12'd4095));
      send_request(mk_req(OP_FREE, 12'd6));
      send_request(mk_req(OP_FOLLOW, 12'd6));
      send_request(mk_req(3'd5, 12'hAAA));
      send_request(mk_req(3'd7, 12'h555));
   endtask

   task automatic test_register_extremes();
      set_geometry(13'd0, 13'h1FFF);
      send_request(mk_req(OP_FORMAT, 12'd0));
      send_request(mk_req(OP_ALLOC, 12'd0));
      send_request(mk_req(OP_FOLLOW, 12'd0));
      // Oversized disk size saturates; every entry is reserved.
      set_geometry(13'h1FFF, 13'd4096);
      send_request(mk_req(OP_FORMAT, 12'd0));
      send_request(mk_req(OP_ALLOC, 12'd0));
      send_request(mk_req(OP_FOLLOW, 12'd4095));
      set_geometry(13'd4096, 13'd3);
      send_request(mk_req(OP_FORMAT, 12'd0));
      send_request(mk_req(OP_ALLOC, 12'd0));
      send_request(mk_req(OP_ADVANCE, 12'd3));
      // Shrinking the disk leaves no free block for the chain tail.
      set_geometry(13'd5, 13'd3);
      send_request(mk_req(OP_FOLLOW, 12'd3));
      send_request(mk_req(OP_ADVANCE, 12'd4));
      send_request(mk_req(OP_ALLOC, 12'd0));
      // Now the link from block 3 points past the end of the disk.
      set_geometry(13'd4, 13'd3);
      send_request(mk_req(OP_FOLLOW, 12'd3));
      send_request(mk_req(OP_FREE, 12'd3));
   endtask

   task automatic test_backpressure();
      int i;
      set_geometry(13'd32, 13'd3);
      send_request(mk_req(OP_FORMAT, 12'd0));
      send_request(mk_req(OP_ALLOC, 12'd0));
      send_request(mk_req(OP_ALLOC, 12'd0));
      // The receiver holds off long enough for the block to stall its input.
      hold_left <= 400;
      for (i = 0; i < 10; i++)
         send_request(mk_req((i % 2) ? OP_FOLLOW : OP_ADVANCE, BLK_W'(3 + i % 3)));
      drain_results();
   endtask

   task automatic test_random();
      int      ph;
      int      n;
      int      k;
      req_type r;
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               set_geometry(CFG_W'($urandom_range(48, 10)), CFG_W'($urandom_range(6, 0)));
            end
            1: begin
               send_idle_pct = 53;
               rsp_stall_pct = 0;
               set_geometry(CFG_W'($urandom_range(48, 10)), CFG_W'($urandom_range(6, 0)));
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 53;
               set_geometry(13'd4096, CFG_W'($urandom_range(40, 3)));
            end
            default: begin
               send_idle_pct = 9;
               rsp_stall_pct = 9;
               set_geometry(CFG_W'($urandom_range(16, 4)), 13'd0);
            end
         endcase
         send_request(mk_req(OP_FORMAT, 12'd0));
         n = 0;
         while (n < PHASE_ITEMS) begin
            k = $urandom_range(99);
            if (k < 3)
               r = mk_req(OP_FORMAT, BLK_W'($urandom_range(4095)));
            else if (k < 6)
               r = mk_req(3'($urandom_range(7, 5)), BLK_W'($urandom_range(4095)));
            else if (k < 26)
               r = mk_req(OP_ALLOC, BLK_W'($urandom_range(4095)));
            else if (k < 58)
               r = mk_req(OP_ADVANCE, pick_chain_block($urandom_range(99) < 60));
            else if (k < 76)
               r = mk_req(OP_FOLLOW, pick_chain_block(1'b0));
            else if (k < 88)
               r = mk_req(OP_FREE, pick_chain_block(1'b0));
            else if (k < 94)
               r = mk_req(3'($urandom_range(3, 2)), in_range_block());
            else
               r = mk_req(3'($urandom_range(4, 2)), BLK_W'($urandom_range(4095)));
            send_request(r);
            if (r.operation <= OP_FREE) n++;
         end
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   // Receiver: random stalls, or a counted hold-off when one is asked for.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         checked_cnt++;
         if (awaited_q.size() == 0) begin
            fail_cnt++;
            if (mismatch_cnt < SHOW_MAX)
               $display("unexpected result: status %0d block %0d eoc %0d freed %0d",
                        rsp_data.status, rsp_data.block_out, rsp_data.end_of_chain,
                        rsp_data.freed_count);
            mismatch_cnt++;
         end else begin
            head = awaited_q.pop_front();
            if (rsp_data.status !== head.rs.status ||
                rsp_data.block_out !== head.rs.block_out ||
                rsp_data.end_of_chain !== head.rs.end_of_chain ||
                rsp_data.freed_count !== head.rs.freed_count) begin
               fail_cnt++;
               if (mismatch_cnt < SHOW_MAX)
                  $display("mismatch op %0d block %0d: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                           head.rq.operation, head.rq.block,
                           head.rs.status, head.rs.block_out, head.rs.end_of_chain,
                           head.rs.freed_count,
                           rsp_data.status, rsp_data.block_out, rsp_data.end_of_chain,
                           rsp_data.freed_count);
               mismatch_cnt++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_cnt, awaited_q.size());
         $display("tb_fat_chain_allocator: FAIL");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NBLK; i++) fat_tbl[i] = ENTRY_FREE;
      for (int i = 0; i < 8; i++) op_cnt[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_basic_chain();
      test_register_extremes();
      test_backpressure();
      test_random();
      drain_results();
      repeat (30) @(posedge clock);
      $display("Covered %0d format, %0d allocate, %0d advance, %0d follow, %0d free requests",
               op_cnt[OP_FORMAT], op_cnt[OP_ALLOC], op_cnt[OP_ADVANCE], op_cnt[OP_FOLLOW],
               op_cnt[OP_FREE]);
      $display("plus %0d ignored codes; %0d results checked, %0d failures, %0d cycles",
               op_cnt[5] + op_cnt[6] + op_cnt[7], checked_cnt, fail_cnt, cycle_cnt);
      if (fail_cnt == 0 && awaited_q.size() == 0)
         $display("tb_fat_chain_allocator: PASS");
      else
         $display("tb_fat_chain_allocator: FAIL");
      $finish;
   end

endmodule
